### sv/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// Dense graph shortest path package
// Shared constants and the sequencer state type of the shortest path unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dgsp_pkg;

   localparam int DEF_MAX_NODES = 16;
   localparam int VERTEX_W      = 4;
   localparam int COST_W        = 10;
   localparam int NODE_COUNT_W  = 5;
   localparam int DISTANCE_W    = 16;

   // Stored distances never exceed a cost plus a selected distance below the
   // no-edge value, so eleven bits hold them without saturation.
   localparam int DIST_W = COST_W + 1;

   localparam logic [COST_W-1:0]       NO_EDGE          = COST_W'(999);
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = NODE_COUNT_W'(16);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN  = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_INIT_RD  = 7'b0000010,
      ST_INIT_WR  = 7'b0000100,
      ST_SCAN     = 7'b0001000,
      ST_RELAX_RD = 7'b0010000,
      ST_RELAX_WR = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

### sv/dense_graph_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// Dense graph shortest path unit
// Holds a cost matrix loaded entry by entry and runs a single source shortest
// path search over it, one vertex or one edge per step of a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Contents
//  req_*     in         valid / stall    load of one cost entry, or run item
//  rsp_*     out        valid / stall    vertex, distance, parent, last
//  csr_*     in         valid / ready    node_count register write
//
//  A run over N vertices sets up the table, then runs up to N-1 rounds of a
//  scan over all vertices followed by a relax pass, then reports; setup and
//  relax read the single cost memory read port once per vertex.
//  Reset clears control state and the visited marks, not the cost matrix.
//  A stall on rsp holds the result register and stretches the report phase.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_graph_shortest_path_unit #(
   parameter int MAX_NODES = dgsp_pkg::DEF_MAX_NODES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [dgsp_pkg::VERTEX_W-1:0]     req_row,
   input  wire logic [dgsp_pkg::VERTEX_W-1:0]     req_col,
   input  wire logic [dgsp_pkg::COST_W-1:0]       req_cost,
   input  wire logic [dgsp_pkg::VERTEX_W-1:0]     req_source_vertex,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [dgsp_pkg::VERTEX_W-1:0]          rsp_vertex,
   output logic [dgsp_pkg::DISTANCE_W-1:0]        rsp_distance,
   output logic [dgsp_pkg::VERTEX_W-1:0]          rsp_parent,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dgsp_pkg::NODE_COUNT_W-1:0] csr_node_count
);
   import dgsp_pkg::*;

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NODES);

   logic [COST_W-1:0] cost_mem [MAX_NODES][MAX_NODES];
   logic [COST_W-1:0] mem_q_ff;
   logic [IW-1:0]     rd_row;

   logic [DIST_W-1:0] dist_ff   [MAX_NODES];
   logic [IW-1:0]     parent_ff [MAX_NODES];
   logic              vis_ff    [MAX_NODES];

   state_type state_ff, state_in;
   logic [NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] iter_ff, iter_in;
   logic [CW-1:0] last_ff, last_in;
   logic [IW-1:0] src_ff, src_in;
   logic [IW-1:0] u_ff, u_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic found_ff, found_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [DISTANCE_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic [VERTEX_W-1:0] rsp_parent_ff, rsp_parent_in;
   logic rsp_last_ff, rsp_last_in;

   logic [CW-1:0] n_active;
   logic [CW-1:0] n_m1;
   logic [IW-1:0] cidx;
   logic [DIST_W-1:0] cur_dist;
   logic [DIST_W-1:0] relax_sum;
   logic scan_take;
   logic relax_take;
   logic [COST_W-1:0] best_next;
   logic [IW-1:0] u_next;
   logic found_next;
   logic req_xfer;
   logic load_ok;
   logic run_ok;
   logic out_free;
   logic table_we;
   logic [DIST_W-1:0] dist_wd;
   logic [IW-1:0] parent_wd;
   logic init_we;
   logic mark_we;

   assign req_stall    = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vertex   = rsp_vertex_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_parent   = rsp_parent_ff;
   assign rsp_last     = rsp_last_ff;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (node_count_ff == '0) begin
         n_active = CNT_ONE;
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n_active = CNT_MAX;
      end else begin
         n_active = CW'(node_count_ff);
      end
   end

   assign load_ok = (32'(req_row) < MAX_NODES) && (32'(req_col) < MAX_NODES);
   assign run_ok  = 32'(req_source_vertex) < 32'(n_active);

   assign n_m1 = n_ff - CNT_ONE;
   assign cidx = cnt_ff[IW-1:0];
   assign cur_dist = dist_ff[cidx];

   assign scan_take = !vis_ff[cidx] && (cur_dist < DIST_W'(best_ff));
   assign best_next = scan_take ? cur_dist[COST_W-1:0] : best_ff;
   assign u_next = scan_take ? cidx : u_ff;
   assign found_next = found_ff || scan_take;

   assign relax_sum = DIST_W'(best_ff) + DIST_W'(mem_q_ff);
   assign relax_take = !vis_ff[cidx] && (relax_sum < cur_dist);

   assign rd_row = (state_ff == ST_RELAX_RD) ? u_ff : src_ff;

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_xfer && (req_mode == MODE_LOAD) && load_ok) begin
         cost_mem[IW'(req_row)][IW'(req_col)] <= req_cost;
      end
      mem_q_ff <= cost_mem[rd_row][cidx];
   end

   always_comb begin
      table_we  = 1'b0;
      dist_wd   = DIST_W'(mem_q_ff);
      parent_wd = src_ff;
      init_we   = 1'b0;
      mark_we   = 1'b0;
      unique case (state_ff)
         ST_INIT_WR: begin
            table_we = 1'b1;
            init_we  = 1'b1;
         end
         ST_SCAN: begin
            mark_we = (cnt_ff == n_m1) && found_next;
         end
         ST_RELAX_WR: begin
            table_we  = relax_take;
            dist_wd   = relax_sum;
            parent_wd = u_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         dist_ff[cidx]   <= dist_wd;
         parent_ff[cidx] <= parent_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_NODES; k++) begin
            vis_ff[k] <= 1'b0;
         end
      end else if (init_we) begin
         vis_ff[cidx] <= (cidx == src_ff);
      end else if (mark_we) begin
         vis_ff[u_next] <= 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      node_count_in   = node_count_ff;
      n_in            = n_ff;
      cnt_in          = cnt_ff;
      iter_in         = iter_ff;
      last_in         = last_ff;
      src_in          = src_ff;
      u_in            = u_ff;
      best_in         = best_ff;
      found_in        = found_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_vertex_in   = rsp_vertex_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_parent_in   = rsp_parent_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_mode == MODE_RUN) && run_ok) begin
               n_in     = n_active;
               src_in   = IW'(req_source_vertex);
               cnt_in   = '0;
               iter_in  = CNT_ONE;
               last_in  = (CW'(req_source_vertex) == n_active - CNT_ONE) ?
                          n_active - CW'(2) : n_active - CNT_ONE;
               state_in = ST_INIT_RD;
            end
         end
         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            if (cnt_ff == n_m1) begin
               cnt_in   = '0;
               best_in  = NO_EDGE;
               found_in = 1'b0;
               state_in = (n_ff == CNT_ONE) ? ST_IDLE : ST_SCAN;
            end else begin
               cnt_in   = cnt_ff + CNT_ONE;
               state_in = ST_INIT_RD;
            end
         end
         ST_SCAN: begin
            best_in  = best_next;
            u_in     = u_next;
            found_in = found_next;
            if (cnt_ff == n_m1) begin
               cnt_in   = '0;
               state_in = found_next ? ST_RELAX_RD : ST_EMIT;
            end else begin
               cnt_in = cnt_ff + CNT_ONE;
            end
         end
         ST_RELAX_RD: begin
            state_in = ST_RELAX_WR;
         end
         ST_RELAX_WR: begin
            if (cnt_ff == n_m1) begin
               cnt_in = '0;
               if (iter_ff + CNT_ONE < n_ff) begin
                  iter_in  = iter_ff + CNT_ONE;
                  best_in  = NO_EDGE;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               cnt_in   = cnt_ff + CNT_ONE;
               state_in = ST_RELAX_RD;
            end
         end
         ST_EMIT: begin
            if (cidx == src_ff) begin
               cnt_in = cnt_ff + CNT_ONE;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_vertex_in   = VERTEX_W'(cidx);
               rsp_distance_in = DISTANCE_W'(cur_dist);
               rsp_parent_in   = VERTEX_W'(parent_ff[cidx]);
               rsp_last_in     = (cnt_ff == last_ff);
               cnt_in          = cnt_ff + CNT_ONE;
               if (cnt_ff == last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      cnt_ff          <= cnt_in;
      iter_ff         <= iter_in;
      last_ff         <= last_in;
      src_ff          <= src_in;
      u_ff            <= u_in;
      best_ff         <= best_in;
      found_ff        <= found_in;
      rsp_vertex_ff   <= rsp_vertex_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_parent_ff   <= rsp_parent_in;
      rsp_last_ff     <= rsp_last_in;
   end

endmodule

`default_nettype wire

### sv/dgsp_checker.sv
// ----------------------------------------------------------------------------
// Dense graph shortest path checker
// Port-level properties of the shortest path unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dgsp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              req_mode,
   input wire logic [dgsp_pkg::VERTEX_W-1:0]     req_row,
   input wire logic [dgsp_pkg::VERTEX_W-1:0]     req_col,
   input wire logic [dgsp_pkg::COST_W-1:0]       req_cost,
   input wire logic [dgsp_pkg::VERTEX_W-1:0]     req_source_vertex,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [dgsp_pkg::VERTEX_W-1:0]     rsp_vertex,
   input wire logic [dgsp_pkg::DISTANCE_W-1:0]   rsp_distance,
   input wire logic [dgsp_pkg::VERTEX_W-1:0]     rsp_parent,
   input wire logic                              rsp_last,
   input wire logic                              csr_valid,
   input wire logic                              csr_ready,
   input wire logic [dgsp_pkg::NODE_COUNT_W-1:0] csr_node_count
);
   import dgsp_pkg::*;

   // A result held under stall keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vertex) &&
         $stable(rsp_distance) && $stable(rsp_parent) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // A load transfer leaves the request channel free in the next cycle.
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_LOAD) |=> !req_stall)
      else $error("load transfer did not free the request channel");

   // While a non-final result is pending, the run is still in progress.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request channel open during a run report");

   // The register port is always open.
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind dense_graph_shortest_path_unit dgsp_checker u_dgsp_checker (.*);

`default_nettype wire
